@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk_i and switched off while rst_ni is low.
`define USF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked during reset.
`define USF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/usf_pkg.sv @@
// ---------------------------------------------------------------------------
// UTF-8 stop sequence filter package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usf_pkg;

  localparam int unsigned MaxResults = 54;
  localparam int unsigned ResCntW    = 6;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_STOP_LOW  = 2'd0;
  localparam logic [1:0] CFG_STOP_HIGH = 2'd1;
  localparam logic [1:0] CFG_STOP_LEN  = 2'd2;

  // Input kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Lead and continuation byte bounds.
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [7:0] LEAD_SURR  = 8'hed;
  localparam logic [7:0] SURR_LO    = 8'ha0;
  localparam logic [7:0] PLANE1_LO  = 8'h90;
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  // Replacement character U+FFFD.
  localparam logic [7:0] REPL_B0 = 8'hef;
  localparam logic [7:0] REPL_B1 = 8'hbf;
  localparam logic [7:0] REPL_B2 = 8'hbd;

  typedef struct packed {
    logic accept;
    logic search;
    logic unit_start;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic rem_zero;
    logic brk;
    logic step_ok;
    logic unit_last;
    logic held_valid;
    logic out_free;
  } status_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = REPL_B0;
      2'd1: b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ design/utf8_stop_sequence_filter.sv @@
// After an item is taken, the block runs the stop search. Each character or
// replacement is then decoded and its bytes emitted one by one; a unit
// dropped for lack of result room has its bytes consumed without output.
// A last decode finds nothing more to emit, a flush closes the run, and only
// then is the next item taken. Output stall can hold the emission and the
// flush. An item that is swallowed goes straight back to idle. Input is
// taken one item at a time. The result beat with run_end set is the last one
// of its item; an item that yields nothing gives no beat. After the stop
// string has been seen, every item is swallowed until reset. Configuration
// is meant to be written while idle.

// ---------------------------------------------------------------------------
// UTF-8 stop sequence filter
// Passes validated UTF-8 byte by byte, replaces ill-formed bytes with
// U+FFFD and cuts the stream at a configurable stop string.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_stop_sequence_filter #(
  parameter int unsigned STOP_MAX      = 16,
  parameter int unsigned PENDING_DEPTH = 19
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_end_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  usf_pkg::cmd_t    cmd;
  usf_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  usf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  usf_datapath #(
    .STOP_MAX      (STOP_MAX),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

`default_nettype wire

@@ design/usf_ctrl.sv @@
// ---------------------------------------------------------------------------
// UTF-8 stop sequence filter controller
// Sequences append, stop search, per-character emission and final flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire usf_pkg::status_t st_i,
  output usf_pkg::cmd_t        cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_UNIT   = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!st_i.drop) state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = ST_UNIT;
      end
      ST_UNIT: begin
        if (st_i.rem_zero || st_i.brk) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.unit_start = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st_i.step_ok) begin
          cmd_o.step = 1'b1;
          if (st_i.unit_last) state_d = ST_UNIT;
        end
      end
      ST_FLUSH: begin
        if (!st_i.held_valid || st_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/usf_datapath.sv @@
// ---------------------------------------------------------------------------
// UTF-8 stop sequence filter datapath
// Pending byte shift store, stop window compare, sequence decode and the
// one-beat look-ahead that marks the last result of an item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usf_datapath #(
  parameter int unsigned STOP_MAX      = 16,
  parameter int unsigned PENDING_DEPTH = 19
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             kind_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [63:0]      cfg_data_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  run_end_o,
  input  wire usf_pkg::cmd_t    cmd_i,
  output usf_pkg::status_t      st_o
);

  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned SW = $clog2(STOP_MAX + 1);
  localparam int unsigned EW = $clog2(PENDING_DEPTH + STOP_MAX + 1);
  localparam int unsigned RW = usf_pkg::ResCntW;

  logic [63:0]   stop_low_q, stop_high_q;
  logic [4:0]    stop_len_q;
  logic [7:0]    pend_q [PENDING_DEPTH];
  logic [CW-1:0] count_q, rem_q;
  logic          stop_found_q, final_q;
  logic          repl_q, drop_q;
  logic [2:0]    ucnt_q;
  logic [1:0]    idx_q;
  logic [RW-1:0] res_cnt_q;
  logic          res_full_q;
  logic          held_valid_q;
  logic [7:0]    held_q;
  logic          out_valid_q, run_end_q;
  logic [7:0]    out_byte_q;

  logic [SW-1:0] slen;
  logic [CW-1:0] emit_v;
  logic          hit_full;
  logic          out_free;

  // ---- stop window search over every start position at once ----
  always_comb begin
    logic [7:0]    sb;
    logic          m;
    logic [EW-1:0] end_i;
    slen     = (stop_len_q > 5'(STOP_MAX)) ? SW'(STOP_MAX) : SW'(stop_len_q);
    emit_v   = count_q;
    hit_full = 1'b0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      m = 1'b1;
      for (int k = 0; k < STOP_MAX; k++) begin
        sb = (k < 8) ? stop_low_q[(k % 8) * 8 +: 8] : stop_high_q[(k % 8) * 8 +: 8];
        if (i + k < PENDING_DEPTH) begin
          if ((SW'(k) < slen) && (CW'(i + k) < count_q) && (pend_q[i + k] != sb)) begin
            m = 1'b0;
          end
        end
      end
      end_i = EW'(i) + EW'(slen);
      if ((slen != '0) && (CW'(i) < count_q) && m) begin
        if (end_i <= EW'(count_q)) begin
          emit_v   = CW'(i);
          hit_full = 1'b1;
        end else begin
          emit_v   = final_q ? count_q : CW'(i);
          hit_full = 1'b0;
        end
      end
    end
  end

  // ---- decode of the sequence at the head of the store ----
  logic [2:0] lw, ulen, uwidth;
  logic       lead_bad, incomplete, seq_bad, urepl;
  always_comb begin
    logic [7:0] a, b;
    a = pend_q[0];
    b = pend_q[1];
    lead_bad = 1'b0;
    if (a < usf_pkg::ASCII_TOP) lw = 3'd1;
    else if (a >= usf_pkg::LEAD2_LO && a <= usf_pkg::LEAD2_HI) lw = 3'd2;
    else if (a >= usf_pkg::LEAD3_LO && a <= usf_pkg::LEAD3_HI) lw = 3'd3;
    else if (a >= usf_pkg::LEAD4_LO && a <= usf_pkg::LEAD4_HI) lw = 3'd4;
    else begin
      lw       = 3'd1;
      lead_bad = 1'b1;
    end
    incomplete = !lead_bad && (rem_q < CW'(lw));
    seq_bad    = lead_bad;
    for (int i = 1; i < 4; i++) begin
      if ((3'(i) < lw) && ((pend_q[i] & usf_pkg::CONT_MASK) != usf_pkg::CONT_TAG)) begin
        seq_bad = 1'b1;
      end
    end
    if ((a == usf_pkg::LEAD3_LO && b < usf_pkg::SURR_LO) ||
        (a == usf_pkg::LEAD_SURR && b >= usf_pkg::SURR_LO) ||
        (a == usf_pkg::LEAD4_LO && b < usf_pkg::PLANE1_LO) ||
        (a == usf_pkg::LEAD4_HI && b >= usf_pkg::PLANE1_LO)) begin
      seq_bad = 1'b1;
    end
    urepl  = incomplete || seq_bad;
    uwidth = urepl ? 3'd1 : lw;
    ulen   = urepl ? 3'd3 : lw;
  end

  logic fits;
  assign fits = !res_full_q &&
                ((7'(res_cnt_q) + 7'(ulen)) <= 7'(usf_pkg::MaxResults));

  assign out_free = !out_valid_q || !out_stall_i;

  assign st_o.drop       = stop_found_q || ((kind_i == usf_pkg::KIND_TEXT) &&
                                            (count_q == CW'(PENDING_DEPTH)));
  assign st_o.rem_zero   = (rem_q == '0);
  assign st_o.brk        = incomplete && !final_q && !stop_found_q;
  assign st_o.step_ok    = drop_q || !held_valid_q || out_free;
  assign st_o.unit_last  = (ucnt_q == 3'd1);
  assign st_o.held_valid = held_valid_q;
  assign st_o.out_free   = out_free;

  logic       do_shift, produce;
  logic [7:0] new_byte;
  assign produce  = cmd_i.step && !drop_q;
  assign do_shift = cmd_i.step && (drop_q || !repl_q || (idx_q == 2'd0));
  assign new_byte = repl_q ? usf_pkg::repl_byte(idx_q) : pend_q[0];

  // Pending store: append at the fill level, shift towards the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !st_o.drop && (kind_i == usf_pkg::KIND_TEXT)) begin
      for (int j = 0; j < PENDING_DEPTH; j++) begin
        if (CW'(j) == count_q) pend_q[j] <= data_byte_i;
      end
    end else if (do_shift) begin
      for (int j = 0; j < PENDING_DEPTH - 1; j++) pend_q[j] <= pend_q[j + 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) rem_q <= emit_v;
    else if (do_shift) rem_q <= rem_q - CW'(1);
    if (cmd_i.unit_start) begin
      repl_q <= urepl;
      drop_q <= !fits;
      ucnt_q <= fits ? ulen : uwidth;
      idx_q  <= 2'd0;
    end else if (cmd_i.step) begin
      ucnt_q <= ucnt_q - 3'd1;
      idx_q  <= idx_q + 2'd1;
    end
    if (produce) held_q <= new_byte;
    if (cmd_i.accept) final_q <= kind_i;
    if (produce && held_valid_q) begin
      out_byte_q <= held_q;
      run_end_q  <= 1'b0;
    end else if (cmd_i.flush && held_valid_q) begin
      out_byte_q <= held_q;
      run_end_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_low_q   <= '0;
      stop_high_q  <= '0;
      stop_len_q   <= '0;
      count_q      <= '0;
      stop_found_q <= 1'b0;
      res_cnt_q    <= '0;
      res_full_q   <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          usf_pkg::CFG_STOP_LOW:  stop_low_q  <= cfg_data_i;
          usf_pkg::CFG_STOP_HIGH: stop_high_q <= cfg_data_i;
          usf_pkg::CFG_STOP_LEN:  stop_len_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && !st_o.drop) begin
        res_cnt_q  <= '0;
        res_full_q <= 1'b0;
        if (kind_i == usf_pkg::KIND_TEXT) count_q <= count_q + CW'(1);
      end else if (do_shift) begin
        count_q <= count_q - CW'(1);
      end else if (cmd_i.flush && stop_found_q) begin
        count_q <= '0;
      end
      if (cmd_i.search && hit_full) stop_found_q <= 1'b1;
      if (cmd_i.unit_start) begin
        if (fits) res_cnt_q <= res_cnt_q + RW'(ulen);
        else res_full_q <= 1'b1;
      end
      if (produce) held_valid_q <= 1'b1;
      else if (cmd_i.flush) held_valid_q <= 1'b0;
      if ((produce && held_valid_q) || (cmd_i.flush && held_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;

endmodule

`default_nettype wire

@@ design/usf_checker.sv @@
// ---------------------------------------------------------------------------
// UTF-8 stop sequence filter checker
// Port-level properties of the filter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module usf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        run_end_o,
  input wire logic        cfg_ready_o
);

  // A stalled result beat holds its contents.
  `USF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(run_end_o), "stalled result beat changed")

  // A beat that is not the last of its item means the item is still in work.
  `USF_ASSERT(a_run_open, out_valid_o && !run_end_o |-> in_stall_o, "input taken while a run is open")

  // A fresh beat appears either mid-item or as the closing beat.
  `USF_ASSERT(a_rise_ctx, $rose(out_valid_o) |-> in_stall_o || run_end_o, "result beat outside an item")

  // Configuration writes are never held off.
  `USF_ASSERT_ALWAYS(a_cfg_ready, rst_ni |-> cfg_ready_o, "configuration port not ready")

endmodule

bind utf8_stop_sequence_filter usf_checker u_usf_checker (.*);

`default_nettype wire

@@ tb/utf8_stop_sequence_filter_test.sv @@
// ---------------------------------------------------------------------------
// UTF-8 stop sequence filter testbench
// Sends text bytes and end items through the filter under several stop
// string settings, predicts every emitted byte and checks each result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stop_sequence_filter_test;

  localparam int unsigned StopMax   = 16;
  localparam int unsigned PendDepth = 19;
  localparam int unsigned BadWidth  = 5;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainWait = 80;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } text_beat_t;

  class utf8_filter_scoreboard;
    logic [63:0] stop_lo, stop_hi;
    logic [4:0]  stop_len;
    logic [7:0]  pend[PendDepth];
    int unsigned pend_cnt;
    bit          stopped;
    text_beat_t  expected_beats[$];
    int unsigned errors, beats_seen;

    function new();
      stop_lo = '0; stop_hi = '0; stop_len = '0;
      pend_cnt = 0; stopped = 0; errors = 0; beats_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        usf_pkg::CFG_STOP_LOW:  stop_lo = val;
        usf_pkg::CFG_STOP_HIGH: stop_hi = val;
        usf_pkg::CFG_STOP_LEN:  stop_len = val[4:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] stop_char(int unsigned k);
      return (k < 8) ? stop_lo[8*k +: 8] : stop_hi[8*(k-8) +: 8];
    endfunction

    function bit matches_at(int unsigned at, int unsigned n);
      for (int unsigned k = 0; k < n; k++)
        if (pend[at+k] != stop_char(k)) return 0;
      return 1;
    endfunction

    // 0 when incomplete, BadWidth for an ill-formed sequence, else the width.
    function int unsigned char_width(int unsigned at, int unsigned avail);
      logic [7:0] a, b;
      int unsigned w;
      a = pend[at];
      if (a < usf_pkg::ASCII_TOP) w = 1;
      else if (a >= usf_pkg::LEAD2_LO && a <= usf_pkg::LEAD2_HI) w = 2;
      else if (a >= usf_pkg::LEAD3_LO && a <= usf_pkg::LEAD3_HI) w = 3;
      else if (a >= usf_pkg::LEAD4_LO && a <= usf_pkg::LEAD4_HI) w = 4;
      else return BadWidth;
      if (avail < w) return 0;
      for (int unsigned i = 1; i < w; i++)
        if ((pend[at+i] & usf_pkg::CONT_MASK) != usf_pkg::CONT_TAG) return BadWidth;
      b = pend[at+1];
      if ((a == usf_pkg::LEAD3_LO && b < usf_pkg::SURR_LO) ||
          (a == usf_pkg::LEAD_SURR && b >= usf_pkg::SURR_LO) ||
          (a == usf_pkg::LEAD4_LO && b < usf_pkg::PLANE1_LO) ||
          (a == usf_pkg::LEAD4_HI && b >= usf_pkg::PLANE1_LO))
        return BadWidth;
      return w;
    endfunction

    function void note_item(logic knd, logic [7:0] data);
      logic [7:0] outq[$];
      bit full;
      int unsigned size, emit, slen, used, hold, w;
      full = 0;
      if (stopped) return;
      if (knd == usf_pkg::KIND_TEXT) begin
        if (pend_cnt >= PendDepth) return;
        pend[pend_cnt] = data;
        pend_cnt++;
      end
      size = pend_cnt;
      emit = size;
      slen = (stop_len > StopMax) ? StopMax : stop_len;
      if (slen != 0) begin
        for (int unsigned i = 0; i + slen <= size; i++)
          if (matches_at(i, slen)) begin
            emit = i;
            stopped = 1;
            break;
          end
        if (!stopped && knd == usf_pkg::KIND_TEXT) begin
          hold = (slen - 1 < size) ? slen - 1 : size;
          while (hold != 0 && !matches_at(size - hold, hold)) hold--;
          emit -= hold;
        end
      end
      used = 0;
      while (used < emit) begin
        w = char_width(used, emit - used);
        if (w == 0 && knd == usf_pkg::KIND_TEXT && !stopped) break;
        if (w == 0 || w == BadWidth) begin
          if (full || outq.size() + 3 > usf_pkg::MaxResults) full = 1;
          else begin
            outq.push_back(usf_pkg::REPL_B0);
            outq.push_back(usf_pkg::REPL_B1);
            outq.push_back(usf_pkg::REPL_B2);
          end
          used++;
        end else begin
          if (full || outq.size() + w > usf_pkg::MaxResults) full = 1;
          else for (int unsigned i = 0; i < w; i++) outq.push_back(pend[used+i]);
          used += w;
        end
      end
      if (stopped) pend_cnt = 0;
      else begin
        for (int unsigned i = 0; i < size - used; i++) pend[i] = pend[used+i];
        pend_cnt = size - used;
      end
      foreach (outq[i]) expected_beats.push_back({outq[i], 1'(i == outq.size() - 1)});
    endfunction

    function void check_beat(logic [7:0] b, logic last);
      text_beat_t e;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: out_byte %02h run_end %0b", b, last);
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %02h, got %02h", e.out_byte, b);
        errors++;
      end
      if (last !== e.run_end) begin
        $error("run_end: expected %0b, got %0b", e.run_end, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, kind_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o, out_stall_i, run_end_o;
  logic [7:0]  out_byte_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  utf8_filter_scoreboard sb;
  bit          quiet;
  int unsigned items_sent, idle_cycles;

  utf8_stop_sequence_filter dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls driven at the falling edge.
  always @(negedge clk_i)
    out_stall_i = !quiet && ($urandom_range(0, 99) < 8);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(out_byte_o, run_end_o);
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1; cfg_index_i = idx; cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic send_item(logic knd, logic [7:0] data);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1; kind_i = knd; data_byte_i = data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(knd, data);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(logic [7:0] data);
    send_item(usf_pkg::KIND_TEXT, data);
  endtask

  task automatic send_end();
    send_item(usf_pkg::KIND_END, 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte(logic [7:0] lo, logic [7:0] hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // One random piece of text: a well-formed character, noise, a partial stop
  // string or an end item.
  task automatic send_random_piece();
    int unsigned r, k, slen;
    logic [7:0] lead;
    r = $urandom_range(0, 99);
    slen = (sb.stop_len > StopMax) ? StopMax : sb.stop_len;
    if (r < 45) begin
      case ($urandom_range(1, 4))
        1: send_text(8'($urandom_range(0, 'h7f)));
        2: begin
          send_text(8'($urandom_range(usf_pkg::LEAD2_LO, usf_pkg::LEAD2_HI)));
          send_text(cont_byte(8'h80, 8'hbf));
        end
        3: begin
          lead = 8'($urandom_range(usf_pkg::LEAD3_LO, usf_pkg::LEAD3_HI));
          send_text(lead);
          send_text(lead == usf_pkg::LEAD3_LO ? cont_byte(8'ha0, 8'hbf) :
                    lead == usf_pkg::LEAD_SURR ? cont_byte(8'h80, 8'h9f) :
                    cont_byte(8'h80, 8'hbf));
          send_text(cont_byte(8'h80, 8'hbf));
        end
        default: begin
          lead = 8'($urandom_range(usf_pkg::LEAD4_LO, usf_pkg::LEAD4_HI));
          send_text(lead);
          send_text(lead == usf_pkg::LEAD4_LO ? cont_byte(8'h90, 8'hbf) :
                    lead == usf_pkg::LEAD4_HI ? cont_byte(8'h80, 8'h8f) :
                    cont_byte(8'h80, 8'hbf));
          send_text(cont_byte(8'h80, 8'hbf));
          send_text(cont_byte(8'h80, 8'hbf));
        end
      endcase
    end else if (r < 70) send_text(8'($urandom));
    else if (r < 85 && slen > 1) begin
      // A proper prefix of the stop string, broken off by a different byte.
      k = $urandom_range(1, slen - 1);
      for (int unsigned i = 0; i < k; i++) send_text(sb.stop_char(i));
      send_text(sb.stop_char(k) ^ 8'($urandom_range(1, 255)));
    end else if (r < 92) send_end();
    else send_text(8'($urandom_range(0, 'h7f)));
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      quiet = (items_sent - start > n / 3) && (items_sent - start < n / 2);
      send_random_piece();
    end
    quiet = 0;
    send_end();
    drain();
  endtask

  initial begin
    logic [7:0] directed[$];
    sb = new();
    quiet = 0; items_sent = 0; idle_cycles = 0;
    rst_ni = 0; in_valid_i = 0; kind_i = usf_pkg::KIND_TEXT; data_byte_i = '0;
    cfg_valid_i = 0; cfg_index_i = usf_pkg::CFG_STOP_LOW; cfg_data_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: extremes, ill-formed leads, overlong forms, surrogates,
    // code points above the last plane and an incomplete sequence flushed.
    directed = '{8'h00, 8'h7f, 8'hc0, 8'hc1, 8'hf5, 8'hff, 8'h80,
                 8'he0, 8'h80, 8'h80, 8'he0, 8'ha0, 8'h80, 8'hed, 8'ha0, 8'h80,
                 8'hf0, 8'h80, 8'hf4, 8'h90, 8'hc2, 8'h80, 8'he2};
    foreach (directed[i]) send_text(directed[i]);
    send_end();
    send_end();
    drain();
    random_phase(60);

    // Longest stop string; the sender also waits once for a full drain.
    write_reg(usf_pkg::CFG_STOP_LOW, 64'h8e_7c_33_a1_5d_42_f9_17);
    write_reg(usf_pkg::CFG_STOP_HIGH, 64'hc8_06_b4_29_e3_71_9a_d5);
    write_reg(usf_pkg::CFG_STOP_LEN, 64'd16);
    random_phase(60);
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    random_phase(60);

    // Length above the maximum, stop bytes that are zero.
    write_reg(usf_pkg::CFG_STOP_LOW, 64'h00_00_5a_00_00_7b_00_00);
    write_reg(usf_pkg::CFG_STOP_HIGH, 64'h00_3c_00_00_00_00_e4_00);
    write_reg(usf_pkg::CFG_STOP_LEN, 64'd31);
    random_phase(90);

    // Stop string of ill-formed bytes, so a flush can overflow the results.
    write_reg(usf_pkg::CFG_STOP_LOW, '1);
    write_reg(usf_pkg::CFG_STOP_HIGH, '1);
    write_reg(usf_pkg::CFG_STOP_LEN, 64'd16);
    for (int unsigned i = 0; i < 15; i++) send_text(8'hff);
    send_text(8'he2);
    send_text(8'h82);
    send_end();
    drain();
    random_phase(80);

    // Short stop string; finally the whole string, after which all is ignored.
    write_reg(usf_pkg::CFG_STOP_LOW, 64'h3e_73_2f_3c);
    write_reg(usf_pkg::CFG_STOP_HIGH, '0);
    write_reg(usf_pkg::CFG_STOP_LEN, 64'd4);
    random_phase(50);
    send_text(8'h41); send_text(8'he2); send_text(8'h3c);
    send_text(8'h2f); send_text(8'h73); send_text(8'h3e);
    for (int unsigned i = 0; i < 12; i++) send_random_piece();
    send_end();
    drain();

    $display("Sent %0d items over five stop settings; checked %0d result beats.",
             items_sent, sb.beats_seen);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
